// ===== rtl/drpdm_pkg.sv =====
// Shared types and constants for the DRAM rank power-down manager.
package drpdm_pkg;

    localparam int BANKS  = 16;
    localparam int BANK_W = $clog2(BANKS + 1);

    typedef enum logic [1:0] {
        REQ_IDLE_ENTRY = 2'd0,
        REQ_BUSY_EXIT  = 2'd1,
        REQ_INTERRUPT  = 2'd2,
        REQ_CMD        = 2'd3
    } req_type_t;

    typedef enum logic [3:0] {
        CMD_ACT    = 4'd0,
        CMD_PRE    = 4'd1,
        CMD_PREA   = 4'd2,
        CMD_PDEA   = 4'd3,
        CMD_PDEP   = 4'd4,
        CMD_SREFEN = 4'd5,
        CMD_PDXA   = 4'd6,
        CMD_PDXP   = 4'd7,
        CMD_SREFEX = 4'd8,
        CMD_REFA   = 4'd9,
        CMD_REFB   = 4'd10
    } issued_cmd_t;

    typedef enum logic [2:0] {
        NEXT_NOP    = 3'd0,
        NEXT_PDEA   = 3'd1,
        NEXT_PDEP   = 3'd2,
        NEXT_SREFEN = 3'd3,
        NEXT_PDXA   = 3'd4,
        NEXT_PDXP   = 3'd5,
        NEXT_SREFEX = 3'd6,
        NEXT_REFA   = 3'd7
    } next_cmd_t;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_ACT_PDN   = 3'd1,
        MODE_PRE_PDN   = 3'd2,
        MODE_SREF      = 3'd3,
        MODE_EXTRA_REF = 3'd4
    } pd_mode_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] issued_cmd;
    } req_t;

    typedef struct packed {
        logic [2:0] next_cmd;
        logic [2:0] mode;
        logic [4:0] open_banks;
    } rsp_t;

endpackage

// ===== rtl/dram_rank_power_down_manager_top.sv =====
// Top level of the DRAM rank power-down manager.
// A result is registered in the result register, or in the skid register
// if a result waits. Throughput: one transaction per cycle while req_stall
// is low; the two-entry output buffer (result register plus skid register)
// lets a new transaction in while a result waits. Reset clears the mode to
// idle, all trigger flags and the open-bank count, and empties the output buffer.
module dram_rank_power_down_manager_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  drpdm_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output drpdm_pkg::rsp_t rsp
);
    import drpdm_pkg::*;

    pd_mode_t          mode_reg, mode_next;
    logic              idle_flag_reg, idle_flag_next;
    logic              entry_pend_reg, entry_pend_next;
    logic              exit_pend_reg, exit_pend_next;
    logic              sref_pend_reg, sref_pend_next;
    logic [BANK_W-1:0] bank_cnt_reg, bank_cnt_next;

    rsp_t   out_reg, skid_reg, result;
    logic   out_valid_reg, skid_valid_reg;
    logic   accept, take_out;
    next_cmd_t wanted;

    assign req_stall = skid_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign accept    = req_valid && !skid_valid_reg;
    assign take_out  = out_valid_reg && !rsp_stall;

    always_comb
    begin
        mode_next       = mode_reg;
        idle_flag_next  = idle_flag_reg;
        entry_pend_next = entry_pend_reg;
        exit_pend_next  = exit_pend_reg;
        sref_pend_next  = sref_pend_reg;
        bank_cnt_next   = bank_cnt_reg;
        case (req.req_type)
            REQ_IDLE_ENTRY:
            begin
                idle_flag_next = 1'b1;
                if (mode_reg == MODE_IDLE)
                    entry_pend_next = 1'b1;
            end
            REQ_BUSY_EXIT:
            begin
                idle_flag_next  = 1'b0;
                sref_pend_next  = 1'b0;
                entry_pend_next = 1'b0;
                if (mode_reg != MODE_IDLE)
                    exit_pend_next = 1'b1;
            end
            REQ_INTERRUPT:
            begin
                entry_pend_next = 1'b0;
                if (mode_reg != MODE_IDLE)
                    exit_pend_next = 1'b1;
            end
            default:
            begin
                case (req.issued_cmd)
                    CMD_ACT:
                        if (bank_cnt_reg < BANK_W'(BANKS))
                            bank_cnt_next = bank_cnt_reg + BANK_W'(1);
                    CMD_PRE:
                        if (bank_cnt_reg != '0)
                            bank_cnt_next = bank_cnt_reg - BANK_W'(1);
                    CMD_PREA:
                        bank_cnt_next = '0;
                    CMD_PDEA:
                    begin
                        mode_next       = MODE_ACT_PDN;
                        entry_pend_next = 1'b0;
                    end
                    CMD_PDEP:
                    begin
                        mode_next       = MODE_PRE_PDN;
                        entry_pend_next = 1'b0;
                    end
                    CMD_SREFEN:
                    begin
                        mode_next       = MODE_SREF;
                        entry_pend_next = 1'b0;
                        sref_pend_next  = 1'b0;
                    end
                    CMD_PDXA:
                    begin
                        mode_next      = MODE_IDLE;
                        exit_pend_next = 1'b0;
                    end
                    CMD_PDXP:
                    begin
                        mode_next      = MODE_IDLE;
                        exit_pend_next = 1'b0;
                        if (idle_flag_reg)
                            sref_pend_next = 1'b1;
                    end
                    CMD_SREFEX:
                        mode_next = MODE_EXTRA_REF;
                    CMD_REFA:
                        if (mode_reg == MODE_EXTRA_REF)
                        begin
                            mode_next      = MODE_IDLE;
                            exit_pend_next = 1'b0;
                        end
                        else if (idle_flag_reg)
                            entry_pend_next = 1'b1;
                    CMD_REFB:
                        if (idle_flag_reg)
                            entry_pend_next = 1'b1;
                    default: ;
                endcase
            end
        endcase
    end

    always_comb
    begin
        wanted = NEXT_NOP;
        if (exit_pend_next)
        begin
            case (mode_next)
                MODE_ACT_PDN:   wanted = NEXT_PDXA;
                MODE_PRE_PDN:   wanted = NEXT_PDXP;
                MODE_SREF:      wanted = NEXT_SREFEX;
                MODE_EXTRA_REF: wanted = NEXT_REFA;
                default:        wanted = NEXT_NOP;
            endcase
        end
        else if (entry_pend_next)
            wanted = (bank_cnt_next != '0) ? NEXT_PDEA : NEXT_PDEP;
        else if (sref_pend_next)
            wanted = NEXT_SREFEN;
        result.next_cmd   = wanted;
        result.mode       = mode_next;
        result.open_banks = 5'(bank_cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            idle_flag_reg  <= 1'b0;
            entry_pend_reg <= 1'b0;
            exit_pend_reg  <= 1'b0;
            sref_pend_reg  <= 1'b0;
            bank_cnt_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            idle_flag_reg  <= idle_flag_next;
            entry_pend_reg <= entry_pend_next;
            exit_pend_reg  <= exit_pend_next;
            sref_pend_reg  <= sref_pend_next;
            bank_cnt_reg   <= bank_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take_out)
                skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (!out_valid_reg || take_out)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (take_out)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take_out)
                out_reg <= skid_reg;
        end
        else if (accept)
        begin
            if (!out_valid_reg || take_out)
                out_reg <= result;
            else
                skid_reg <= result;
        end
    end

    // skid entry only fills behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a transaction while result register is empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        bank_cnt_reg <= BANK_W'(BANKS))
        else $error("open-bank count above bank total");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.req_type == REQ_CMD && req.issued_cmd == CMD_PDEA)
        |=> (mode_reg == MODE_ACT_PDN && !entry_pend_reg))
        else $error("PDEA did not enter active power-down");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.req_type == REQ_BUSY_EXIT)
        |=> (!idle_flag_reg && !sref_pend_reg && !entry_pend_reg))
        else $error("busy exit left entry triggers set");

endmodule
